/* design/battery_compensated_motor_pwm_defines.svh */
// Assertion macros for the battery compensated motor PWM block
`ifndef BATTERY_COMPENSATED_MOTOR_PWM_DEFINES_SVH
`define BATTERY_COMPENSATED_MOTOR_PWM_DEFINES_SVH

// Property that holds at every clock edge outside reset
`define BCMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset
`define BCMP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* design/bcmp_pkg.sv */
// Shared constants for the battery compensated motor PWM block
package bcmp_pkg;

  localparam int MotorCount = 4;
  localparam int MotorIdxW  = $clog2(MotorCount);
  localparam int PwmBits    = 8;

  localparam int IdW     = 2;
  localparam int ThrustW = 16;
  localparam int MvW     = 14;
  localparam int CmpW    = 8;
  localparam int RatioW  = 16;

  localparam int ThrustScale = 60;
  localparam int CoefA       = 654;
  localparam int CoefB       = 92275;
  localparam int CoefAScaled = CoefA * ThrustScale;

  localparam int TsW     = 22;
  localparam int AtW     = 32;
  localparam int KW      = 33;
  localparam int ProdW   = 55;
  localparam int VoltsW  = 18;
  localparam int VScaleW = 26;
  localparam int NW      = VoltsW + VScaleW;
  localparam int RemW    = NW - 16;
  localparam int QW      = RatioW;
  localparam int DivW    = MvW + QW;

  localparam logic [KW-1:0]      CoefBShifted = KW'(CoefB) << 16;
  localparam logic [VScaleW-1:0] VScale       = VScaleW'(1000 * 65535);
  localparam logic [RatioW-1:0]  RatioMax     = '1;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegOutputsEnabled    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCompensationEnable = 1'd1;

endpackage

/* design/battery_compensated_motor_pwm.sv */
// Top level: pipelined battery compensated thrust to PWM compare unit
// One motor command is taken per clock and one result leaves per clock once the pipe is full
// and the output is not stalled. A command passes through three arithmetic stages (thrust
// scaling, the thrust quadratic, the millivolt scaling), a saturation check stage, sixteen
// restoring divider stages that settle one quotient bit each, and the output register.
// Commands taken while outputs are disabled, or for a motor index beyond the motor count,
// give no result. Each stage holds its item while the stage after it is full and stalled,
// so bubbles close up behind a stalled output. Configuration writes are always taken and
// should only be issued while the pipe is empty.
`include "battery_compensated_motor_pwm_defines.svh"

module battery_compensated_motor_pwm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcmp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic                           cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] motor_id, [17:2] thrust, [31:18] battery_mv
  input  logic [31:0]                    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] motor_sel, [9:2] compare_value, [25:10] duty_ratio, [31:26] zero
  output logic [31:0]                    m_axis_tdata
);
  import bcmp_pkg::*;

  // Configuration
  logic out_en_q, comp_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_en_q  <= 1'b0;
      comp_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegOutputsEnabled:     out_en_q  <= cfg_data_i;
        RegCompensationEnable: comp_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input unpacking
  logic [IdW-1:0]     s_id;
  logic [ThrustW-1:0] s_thrust;
  logic [MvW-1:0]     s_mv;
  logic               s_keep;

  assign s_id     = s_axis_tdata[IdW-1:0];
  assign s_thrust = s_axis_tdata[IdW +: ThrustW];
  assign s_mv     = s_axis_tdata[IdW+ThrustW +: MvW];
  assign s_keep   = out_en_q && (int'(s_id) < MotorCount);

  // Stage ready chain
  logic p1_rdy, p2_rdy, p3_rdy, out_rdy;
  logic st_rdy [QW+1];

  logic               p1_v_q, p2_v_q, p3_v_q, out_v_q;
  logic               st_v_q [QW+1];

  assign out_rdy = !out_v_q || m_axis_tready;
  assign st_rdy[QW] = !st_v_q[QW] || out_rdy;
  for (genvar j = 0; j < QW; j++) begin : g_rdy
    assign st_rdy[j] = !st_v_q[j] || st_rdy[j+1];
  end
  assign p3_rdy = !p3_v_q || st_rdy[0];
  assign p2_rdy = !p2_v_q || p3_rdy;
  assign p1_rdy = !p1_v_q || p2_rdy;
  assign s_axis_tready = p1_rdy;

  // Stage 1: scale thrust and form the squared-term coefficient
  logic [TsW-1:0]     p1_ts_q;
  logic [AtW-1:0]     p1_at_q;
  logic [IdW-1:0]     p1_id_q;
  logic [ThrustW-1:0] p1_thr_q;
  logic [MvW-1:0]     p1_mv_q;
  logic               p1_comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_q <= s_axis_tvalid && s_keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy) begin
      p1_ts_q   <= TsW'(s_thrust) * TsW'(ThrustScale);
      p1_at_q   <= AtW'(s_thrust) * AtW'(CoefAScaled);
      p1_id_q   <= s_id;
      p1_thr_q  <= s_thrust;
      p1_mv_q   <= s_mv;
      p1_comp_q <= comp_en_q;
    end
  end

  // Stage 2: needed volts = ts * (B*2^16 - A*ts) / 2^36, always non-negative here
  logic [KW-1:0]      p2_k;
  logic [ProdW-1:0]   p2_prod;
  logic [VoltsW-1:0]  p2_volts_q;
  logic [IdW-1:0]     p2_id_q;
  logic [ThrustW-1:0] p2_thr_q;
  logic [MvW-1:0]     p2_mv_q;
  logic               p2_comp_q;

  assign p2_k    = CoefBShifted - KW'(p1_at_q);
  assign p2_prod = ProdW'(p1_ts_q) * ProdW'(p2_k);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_rdy) begin
      p2_volts_q <= p2_prod[36 +: VoltsW];
      p2_id_q    <= p1_id_q;
      p2_thr_q   <= p1_thr_q;
      p2_mv_q    <= p1_mv_q;
      p2_comp_q  <= p1_comp_q;
    end
  end

  // Stage 3: dividend = volts * 1000 * 65535 / 2^16, floored
  logic [NW-1:0]      p3_n;
  logic [RemW-1:0]    p3_num_q;
  logic [IdW-1:0]     p3_id_q;
  logic [ThrustW-1:0] p3_thr_q;
  logic [MvW-1:0]     p3_mv_q;
  logic               p3_comp_q;

  assign p3_n = NW'(p2_volts_q) * NW'(VScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (p3_rdy) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_rdy) begin
      p3_num_q  <= p3_n[NW-1:16];
      p3_id_q   <= p2_id_q;
      p3_thr_q  <= p2_thr_q;
      p3_mv_q   <= p2_mv_q;
      p3_comp_q <= p2_comp_q;
    end
  end

  // Divider: stage 0 checks saturation, stages 1..QW each settle one quotient bit
  logic [RemW-1:0]    st_rem_q  [QW+1];
  logic [QW-1:0]      st_quo_q  [QW+1];
  logic [MvW-1:0]     st_mv_q   [QW+1];
  logic [IdW-1:0]     st_id_q   [QW+1];
  logic [ThrustW-1:0] st_thr_q  [QW+1];
  logic               st_comp_q [QW+1];
  logic               st_sat_q  [QW+1];

  logic [DivW-1:0] p3_den;
  assign p3_den = {p3_mv_q, {QW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q[0] <= 1'b0;
    end else if (st_rdy[0]) begin
      st_v_q[0] <= p3_v_q;
    end
  end

  // Zero battery voltage falls into saturation as well
  always_ff @(posedge clk_i) begin
    if (st_rdy[0]) begin
      st_rem_q[0]  <= p3_num_q;
      st_quo_q[0]  <= '0;
      st_mv_q[0]   <= p3_mv_q;
      st_id_q[0]   <= p3_id_q;
      st_thr_q[0]  <= p3_thr_q;
      st_comp_q[0] <= p3_comp_q;
      st_sat_q[0]  <= DivW'(p3_num_q) >= p3_den;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [DivW-1:0] trial;
    logic [DivW-1:0] rem_ext;
    logic            take;
    logic [DivW-1:0] diff;

    assign trial   = DivW'(st_mv_q[j-1]) << (QW - j);
    assign rem_ext = DivW'(st_rem_q[j-1]);
    assign take    = rem_ext >= trial;
    assign diff    = rem_ext - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[j] <= 1'b0;
      end else if (st_rdy[j]) begin
        st_v_q[j] <= st_v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (st_rdy[j]) begin
        st_rem_q[j]  <= take ? diff[RemW-1:0] : st_rem_q[j-1];
        st_quo_q[j]  <= st_quo_q[j-1] | (QW'(take) << (QW - j));
        st_mv_q[j]   <= st_mv_q[j-1];
        st_id_q[j]   <= st_id_q[j-1];
        st_thr_q[j]  <= st_thr_q[j-1];
        st_comp_q[j] <= st_comp_q[j-1];
        st_sat_q[j]  <= st_sat_q[j-1];
      end
    end
  end

  // Output register and per-motor ratio store
  logic [RatioW-1:0] fin_ratio;
  logic [RatioW-1:0] fin_shift;
  logic [IdW-1:0]    out_sel_q;
  logic [RatioW-1:0] out_ratio_q;
  logic              out_comp_q;
  logic              out_sat_q;
  logic [RatioW-1:0] last_ratio_q [MotorCount];

  assign fin_ratio = !st_comp_q[QW] ? st_thr_q[QW] :
                     st_sat_q[QW]   ? RatioMax     : st_quo_q[QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      for (int m = 0; m < MotorCount; m++) begin
        last_ratio_q[m] <= '0;
      end
    end else if (out_rdy) begin
      out_v_q <= st_v_q[QW];
      if (st_v_q[QW] && st_comp_q[QW]) begin
        last_ratio_q[st_id_q[QW][MotorIdxW-1:0]] <= fin_ratio;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_sel_q   <= st_id_q[QW];
      out_ratio_q <= fin_ratio;
      out_comp_q  <= st_comp_q[QW];
      out_sat_q   <= st_sat_q[QW];
    end
  end

  assign fin_shift = out_ratio_q >> (RatioW - PwmBits);

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_ratio_q, fin_shift[CmpW-1:0], out_sel_q};

  // Checks
  `BCMP_ASSERT(a_sat_full, out_v_q && out_comp_q && out_sat_q |-> out_ratio_q == RatioMax, "saturated ratio not full scale")
  `BCMP_ASSERT(a_store_match, out_v_q && out_comp_q |-> last_ratio_q[out_sel_q[MotorIdxW-1:0]] == out_ratio_q, "stored ratio differs from result")
  `BCMP_ASSERT(a_drop_disabled, s_axis_tvalid && s_axis_tready && !out_en_q |=> !p1_v_q, "item entered while outputs disabled")

endmodule

/* tb/sv/battery_compensated_motor_pwm_checker.sv */
// Checker that predicts and compares the PWM updates of the battery compensated motor block
module battery_compensated_motor_pwm_checker
  import bcmp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i,
  input  logic               cmd_valid_i,
  input  logic               cmd_ready_i,
  // [1:0] motor_id, [17:2] thrust, [31:18] battery_mv
  input  logic [31:0]        cmd_data_i,
  input  logic               upd_valid_i,
  input  logic               upd_ready_i,
  // [1:0] motor_sel, [9:2] compare_value, [25:10] duty_ratio, [31:26] zero
  input  logic [31:0]        upd_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [MvW-1:0]     battery_mv;
    logic [ThrustW-1:0] thrust;
    logic [IdW-1:0]     motor_id;
  } motor_cmd_t;

  typedef struct packed {
    logic [RatioW-1:0] duty_ratio;
    logic [CmpW-1:0]   compare_value;
    logic [IdW-1:0]    motor_sel;
  } pwm_update_t;

  logic              outputs_enabled;
  logic              compensation_on;
  logic [RatioW-1:0] motor_ratio [MotorCount];
  pwm_update_t       expected_updates [$];
  int                fails;

  // Needed volts from the thrust quadratic, divided by the battery voltage, saturated
  function automatic logic [RatioW-1:0] compensated_duty(logic [ThrustW-1:0] thrust,
                                                         logic [MvW-1:0] battery_mv);
    longint unsigned ts, pos, neg, volts, num, den, quot;
    ts  = 64'(thrust) * ThrustScale;
    pos = (64'(CoefB) * ts) << 16;
    neg = 64'(CoefA) * ts * ts;
    volts = (pos > neg) ? (pos - neg) >> 36 : 64'd0;
    if (battery_mv == '0) return RatioMax;
    num  = volts * 64'd1000 * 64'd65535;
    den  = 64'(battery_mv) << 16;
    quot = num / den;
    return (quot > 64'(RatioMax)) ? RatioMax : RatioW'(quot);
  endfunction

  function automatic logic [CmpW-1:0] duty_to_compare(logic [RatioW-1:0] ratio);
    int unsigned top_bits;
    top_bits = (32'(ratio) >> (RatioW - PwmBits)) & ((32'd1 << PwmBits) - 1);
    return CmpW'(top_bits);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motor_cmd_t        cmd;
    pwm_update_t       got;
    pwm_update_t       want;
    logic [RatioW-1:0] ratio;
    if (!rst_ni) begin
      outputs_enabled = 1'b0;
      compensation_on = 1'b0;
      foreach (motor_ratio[i]) motor_ratio[i] = '0;
      expected_updates.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegOutputsEnabled:     outputs_enabled = cfg_data_i;
          RegCompensationEnable: compensation_on = cfg_data_i;
          default: ;
        endcase
      end

      if (upd_valid_i && upd_ready_i) begin
        got = pwm_update_t'(upd_data_i[$bits(pwm_update_t)-1:0]);
        if (expected_updates.size() == 0) begin
          $error("unexpected item: motor_sel %0d compare_value %0d duty_ratio %0d",
                 got.motor_sel, got.compare_value, got.duty_ratio);
          fails++;
        end else begin
          want = expected_updates.pop_front();
          if (got.motor_sel !== want.motor_sel) begin
            $error("motor_sel: expected %0d, got %0d", want.motor_sel, got.motor_sel);
            fails++;
          end
          if (got.compare_value !== want.compare_value) begin
            $error("compare_value: expected %0d, got %0d",
                   want.compare_value, got.compare_value);
            fails++;
          end
          if (got.duty_ratio !== want.duty_ratio) begin
            $error("duty_ratio: expected %0d, got %0d", want.duty_ratio, got.duty_ratio);
            fails++;
          end
        end
      end

      // Disabled outputs or an unknown motor drop the command silently
      if (cmd_valid_i && cmd_ready_i) begin
        cmd = motor_cmd_t'(cmd_data_i[$bits(motor_cmd_t)-1:0]);
        if (outputs_enabled && (int'(cmd.motor_id) < MotorCount)) begin
          ratio = cmd.thrust;
          if (compensation_on) begin
            ratio = compensated_duty(cmd.thrust, cmd.battery_mv);
            motor_ratio[cmd.motor_id] = ratio;
          end
          want.motor_sel     = cmd.motor_id;
          want.compare_value = duty_to_compare(ratio);
          want.duty_ratio    = ratio;
          expected_updates.push_back(want);
        end
      end

      fail_count_o <= fails;
      pending_o    <= expected_updates.size();
    end
  end

endmodule

/* tb/sv/battery_compensated_motor_pwm_tb.sv */
// Testbench top: drives motor commands and register writes, gives the verdict
module battery_compensated_motor_pwm_tb;
  import bcmp_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int PipeSettle  = 40;
  localparam int PhaseItems  = 50;
  localparam int QuietItems  = 20;
  localparam int PhaseCount  = 9;
  localparam int QuietPhase  = 4;
  localparam int CalmPhase   = 6;
  localparam int HoldPhase   = 1;
  localparam int IdlePercent = 13;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic               cfg_data_i    = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;

  logic calm = 1'b0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;

  battery_compensated_motor_pwm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  battery_compensated_motor_pwm_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .upd_valid_i  (m_axis_tvalid),
    .upd_ready_i  (m_axis_tready),
    .upd_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_cmd(logic [IdW-1:0] motor_id, logic [ThrustW-1:0] thrust,
                          logic [MvW-1:0] battery_mv);
    while (!calm && ($urandom_range(99) < IdlePercent)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {battery_mv, thrust, motor_id};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Realistic single-cell voltages for half the commands, where the clamp sits, else full-range noise
  task automatic send_random_cmd();
    logic [ThrustW-1:0] thrust;
    logic [MvW-1:0]     battery_mv;
    case ($urandom_range(9))
      6:       thrust = ThrustW'($urandom_range(255));
      7:       thrust = ThrustW'(65535 - $urandom_range(255));
      default: thrust = ThrustW'($urandom_range(65535));
    endcase
    case ($urandom_range(9))
      5, 6, 7: battery_mv = MvW'($urandom_range(16383));
      8:       battery_mv = MvW'($urandom_range(50));
      9:       battery_mv = $urandom_range(1) ? '0 : '1;
      default: battery_mv = MvW'($urandom_range(4300, 2500));
    endcase
    send_cmd(IdW'($urandom_range(3)), thrust, battery_mv);
  endtask

  // Hold the sender until every expected item is out and the pipe has emptied
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PipeSettle) @(posedge clk_i);
  endtask

  task automatic set_mode(logic enable, logic compensate);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegOutputsEnabled;
    cfg_data_i  <= enable;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegCompensationEnable;
    cfg_data_i  <= compensate;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int count;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Outputs still disabled after reset: these commands must vanish
    send_cmd(2'd3, 16'hFFFF, 14'd3700);
    send_cmd(2'd0, 16'd1234, 14'd0);
    drain();

    // Raw thrust passes straight through
    set_mode(1'b1, 1'b0);
    send_cmd(2'd0, 16'h0000, 14'd0);
    send_cmd(2'd1, 16'hFFFF, 14'h3FFF);
    send_cmd(2'd2, 16'h8000, 14'd5000);
    send_cmd(2'd3, 16'h00FF, 14'd1);
    drain();

    // Compensated: zero thrust, full thrust, zero battery, clamp, small ratios
    set_mode(1'b1, 1'b1);
    send_cmd(2'd0, 16'h0000, 14'd4000);
    send_cmd(2'd1, 16'hFFFF, 14'h3FFF);
    send_cmd(2'd2, 16'hFFFF, 14'd0);
    send_cmd(2'd3, 16'h0000, 14'd0);
    send_cmd(2'd3, 16'd30000, 14'd100);
    send_cmd(2'd0, 16'd40000, 14'd4200);
    send_cmd(2'd1, 16'd20000, 14'd3700);
    send_cmd(2'd2, 16'hFFFF, 14'd3000);
    send_cmd(2'd3, 16'h0001, 14'h3FFF);
    send_cmd(2'd0, 16'h8000, 14'd8191);
    send_cmd(2'd1, 16'd50000, 14'd11100);
    send_cmd(2'd2, 16'h7FFF, 14'h2AAA);
    send_cmd(2'd1, 16'h5555, 14'h1555);
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      set_mode(p != QuietPhase, (p % 2) == 1);
      calm <= (p == CalmPhase);
      count = (p == QuietPhase) ? QuietItems : PhaseItems;
      for (int i = 0; i < count; i++) begin
        if (p == HoldPhase && i == count / 2) drain();
        send_random_cmd();
      end
      drain();
    end

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
